// File: src/two_point_circle_centres_unit_defines.svh
// Assertion macros for the circle centre unit.
// Each macro names the assertion, takes an enabling condition and a property,
// and checks on the rising edge of clk while rst_n is high.
`ifndef TWO_POINT_CIRCLE_CENTRES_UNIT_DEFINES_SVH
`define TWO_POINT_CIRCLE_CENTRES_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TPCC_ASSERT_HOLDS(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("tpcc assertion failed");
`define TPCC_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("tpcc assertion failed");
`else
`define TPCC_ASSERT_HOLDS(name, cond, prop)
`define TPCC_ASSERT_NEXT(name, cond, prop)
`endif
`endif

// File: src/tpcc_pkg.sv
package tpcc_pkg;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 33;
    localparam int SQ_W     = 65;
    localparam int D2_W     = 66;
    localparam int RADIUS_W = 48;
    localparam int MAG_W    = 34;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_COINCIDENT = 2'd1,
        ST_FAR        = 2'd2
    } status_t;

    typedef struct packed {
        status_t                    status;
        logic                       x_neg;
        logic                       y_neg;
        logic signed [DIFF_W-1:0]   sum_x;
        logic signed [DIFF_W-1:0]   sum_y;
    } side_t;

endpackage

// File: src/tpcc_front.sv
module tpcc_front import tpcc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    localparam int QW = 50 + FRAC_BITS,
    localparam int NW = 65 + QW
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [COORD_W-1:0]   first_x,
    input  logic signed [COORD_W-1:0]   first_y,
    input  logic signed [COORD_W-1:0]   second_x,
    input  logic signed [COORD_W-1:0]   second_y,
    input  logic [RADIUS_W-1:0]         radius_sq,
    output logic                        out_valid,
    output side_t                       out_side,
    output logic [D2_W-1:0]             out_d2,
    output logic [NW-1:0]               out_nx,
    output logic [NW-1:0]               out_ny
);

    localparam int SW = (QW > D2_W) ? QW : D2_W;

    // Stage A: differences and sums.
    logic                       a_valid_reg;
    logic signed [DIFF_W-1:0]   dx_reg, dy_reg;
    side_t                      a_side_reg;
    side_t                      a_side_next;
    logic signed [DIFF_W-1:0]   dx_next, dy_next;

    // Stage B: squares.
    logic                       b_valid_reg;
    logic [SQ_W-1:0]            sx2_reg, sy2_reg;
    side_t                      b_side_reg;
    logic [DIFF_W-1:0]          ax, ay;

    // Stage C: squared distance.
    logic                       c_valid_reg;
    logic [SQ_W-1:0]            c_sx2_reg, c_sy2_reg;
    logic [D2_W-1:0]            d2_reg;
    side_t                      c_side_reg;

    // Stage D: range checks and headroom.
    logic                       d_valid_reg;
    logic [SQ_W-1:0]            d_sx2_reg, d_sy2_reg;
    logic [D2_W-1:0]            d_d2_reg;
    logic [QW-1:0]              q_reg;
    side_t                      d_side_reg;
    logic [QW-1:0]              four_r;
    logic [QW-1:0]              q_next;
    logic                       far;
    logic                       zero;
    side_t                      d_side_next;

    // Stage E: partial products.
    logic                       e_valid_reg;
    logic [D2_W-1:0]            e_d2_reg;
    side_t                      e_side_reg;
    logic [65:0]                px_ll_reg, py_ll_reg;
    logic [QW-1:0]              px_lh_reg, py_lh_reg;
    logic [64:0]                px_hl_reg, py_hl_reg;
    logic [QW-2:0]              px_hh_reg, py_hh_reg;

    // Stage F: full products.
    logic                       f_valid_reg;
    logic [D2_W-1:0]            f_d2_reg;
    side_t                      f_side_reg;
    logic [NW-1:0]              nx_reg, ny_reg;

    always_comb
    begin
        dx_next            = DIFF_W'(first_x) - DIFF_W'(second_x);
        dy_next            = DIFF_W'(first_y) - DIFF_W'(second_y);
        a_side_next.status = ST_OK;
        a_side_next.x_neg  = dx_next[DIFF_W-1];
        a_side_next.y_neg  = dy_next[DIFF_W-1];
        a_side_next.sum_x  = DIFF_W'(first_x) + DIFF_W'(second_x);
        a_side_next.sum_y  = DIFF_W'(first_y) + DIFF_W'(second_y);
    end

    assign ax = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
    assign ay = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);

    always_comb
    begin
        four_r = QW'(radius_sq) << (FRAC_BITS + 2);
        zero   = (d2_reg == '0);
        far    = SW'(d2_reg) > SW'(four_r);
        q_next = four_r - QW'(d2_reg);
        d_side_next = c_side_reg;
        if (zero)
        begin
            d_side_next.status = ST_COINCIDENT;
        end
        else if (far)
        begin
            d_side_next.status = ST_FAR;
        end
        else
        begin
            d_side_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            a_side_reg <= a_side_next;

            sx2_reg    <= SQ_W'(ax) * SQ_W'(ax);
            sy2_reg    <= SQ_W'(ay) * SQ_W'(ay);
            b_side_reg <= a_side_reg;

            c_sx2_reg  <= sx2_reg;
            c_sy2_reg  <= sy2_reg;
            d2_reg     <= D2_W'(sx2_reg) + D2_W'(sy2_reg);
            c_side_reg <= b_side_reg;

            d_sx2_reg  <= c_sx2_reg;
            d_sy2_reg  <= c_sy2_reg;
            d_d2_reg   <= d2_reg;
            q_reg      <= q_next;
            d_side_reg <= d_side_next;

            px_ll_reg  <= 66'(d_sx2_reg[32:0]) * 66'(q_reg[32:0]);
            px_lh_reg  <= QW'(d_sx2_reg[32:0]) * QW'(q_reg[QW-1:33]);
            px_hl_reg  <= 65'(d_sx2_reg[64:33]) * 65'(q_reg[32:0]);
            px_hh_reg  <= (QW-1)'(d_sx2_reg[64:33]) * (QW-1)'(q_reg[QW-1:33]);
            py_ll_reg  <= 66'(d_sy2_reg[32:0]) * 66'(q_reg[32:0]);
            py_lh_reg  <= QW'(d_sy2_reg[32:0]) * QW'(q_reg[QW-1:33]);
            py_hl_reg  <= 65'(d_sy2_reg[64:33]) * 65'(q_reg[32:0]);
            py_hh_reg  <= (QW-1)'(d_sy2_reg[64:33]) * (QW-1)'(q_reg[QW-1:33]);
            e_d2_reg   <= d_d2_reg;
            e_side_reg <= d_side_reg;

            nx_reg     <= NW'(px_ll_reg) + (NW'(px_lh_reg) << 33)
                        + (NW'(px_hl_reg) << 33) + (NW'(px_hh_reg) << 66);
            ny_reg     <= NW'(py_ll_reg) + (NW'(py_lh_reg) << 33)
                        + (NW'(py_hl_reg) << 33) + (NW'(py_hh_reg) << 66);
            f_d2_reg   <= e_d2_reg;
            f_side_reg <= e_side_reg;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_side  = f_side_reg;
    assign out_d2    = f_d2_reg;
    assign out_nx    = nx_reg;
    assign out_ny    = ny_reg;

endmodule

// File: src/tpcc_root.sv
module tpcc_root import tpcc_pkg::*;
#(
    parameter int NW = 131
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  side_t               in_side,
    input  logic [D2_W-1:0]     in_d2,
    input  logic [NW-1:0]       in_nx,
    input  logic [NW-1:0]       in_ny,
    output logic                out_valid,
    output side_t               out_side,
    output logic [MAG_W-1:0]    out_mx,
    output logic [MAG_W-1:0]    out_my
);

    // Each stage decides one bit of floor(sqrt(n / d2)), keeping the
    // remainder n - m*m*d2 and the running product m*d2.
    localparam int STEPS = MAG_W;
    localparam int CW    = (NW > 135) ? NW : 135;
    localparam int TW    = 100;

    logic               v_in   [0:STEPS-1];
    side_t              s_in   [0:STEPS-1];
    logic [D2_W-1:0]    d_in   [0:STEPS-1];
    logic [CW-1:0]      rx_in  [0:STEPS-1];
    logic [CW-1:0]      ry_in  [0:STEPS-1];
    logic [TW-1:0]      tx_in  [0:STEPS-1];
    logic [TW-1:0]      ty_in  [0:STEPS-1];
    logic [MAG_W-1:0]   mx_in  [0:STEPS-1];
    logic [MAG_W-1:0]   my_in  [0:STEPS-1];

    logic               v_reg  [0:STEPS-1];
    side_t              s_reg  [0:STEPS-1];
    logic [D2_W-1:0]    d_reg  [0:STEPS-1];
    logic [CW-1:0]      rx_reg [0:STEPS-1];
    logic [CW-1:0]      ry_reg [0:STEPS-1];
    logic [TW-1:0]      tx_reg [0:STEPS-1];
    logic [TW-1:0]      ty_reg [0:STEPS-1];
    logic [MAG_W-1:0]   mx_reg [0:STEPS-1];
    logic [MAG_W-1:0]   my_reg [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int B = STEPS - 1 - k;

        logic [CW-1:0]  cand_x, cand_y;
        logic           take_x, take_y;

        if (k == 0)
        begin : g_first
            assign v_in[k]  = in_valid;
            assign s_in[k]  = in_side;
            assign d_in[k]  = in_d2;
            assign rx_in[k] = CW'(in_nx);
            assign ry_in[k] = CW'(in_ny);
            assign tx_in[k] = '0;
            assign ty_in[k] = '0;
            assign mx_in[k] = '0;
            assign my_in[k] = '0;
        end
        else
        begin : g_next
            assign v_in[k]  = v_reg[k-1];
            assign s_in[k]  = s_reg[k-1];
            assign d_in[k]  = d_reg[k-1];
            assign rx_in[k] = rx_reg[k-1];
            assign ry_in[k] = ry_reg[k-1];
            assign tx_in[k] = tx_reg[k-1];
            assign ty_in[k] = ty_reg[k-1];
            assign mx_in[k] = mx_reg[k-1];
            assign my_in[k] = my_reg[k-1];
        end

        assign cand_x = (CW'(tx_in[k]) << (B + 1)) + (CW'(d_in[k]) << (2 * B));
        assign cand_y = (CW'(ty_in[k]) << (B + 1)) + (CW'(d_in[k]) << (2 * B));
        assign take_x = (cand_x <= rx_in[k]);
        assign take_y = (cand_y <= ry_in[k]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k]  <= s_in[k];
                d_reg[k]  <= d_in[k];
                rx_reg[k] <= take_x ? rx_in[k] - cand_x : rx_in[k];
                ry_reg[k] <= take_y ? ry_in[k] - cand_y : ry_in[k];
                tx_reg[k] <= take_x ? tx_in[k] + (TW'(d_in[k]) << B) : tx_in[k];
                ty_reg[k] <= take_y ? ty_in[k] + (TW'(d_in[k]) << B) : ty_in[k];
                mx_reg[k] <= mx_in[k] | (MAG_W'(take_x) << B);
                my_reg[k] <= my_in[k] | (MAG_W'(take_y) << B);
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_side  = s_reg[STEPS-1];
    assign out_mx    = mx_reg[STEPS-1];
    assign out_my    = my_reg[STEPS-1];

endmodule

// File: src/tpcc_back.sv
module tpcc_back import tpcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  side_t               in_side,
    input  logic [MAG_W-1:0]    in_mx,
    input  logic [MAG_W-1:0]    in_my,
    output logic                en,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [127:0]        m_tdata,
    output logic [1:0]          m_tuser
);

    localparam logic [MAG_W-1:0] OFFSET_CAP = MAG_W'(64'd1 << 33);

    typedef struct packed {
        status_t        status;
        logic [31:0]    b_y;
        logic [31:0]    b_x;
        logic [31:0]    a_y;
        logic [31:0]    a_x;
    } result_t;

    function automatic logic [31:0] half_sat(input logic signed [35:0] v);
        logic signed [35:0] h;
        begin
            h = v >>> 1;
            if (h > 36'sd2147483647)
            begin
                return 32'h7fffffff;
            end
            else if (h < -36'sd2147483648)
            begin
                return 32'h80000000;
            end
            else
            begin
                return h[31:0];
            end
        end
    endfunction

    logic [MAG_W-1:0]   cap_x, cap_y;
    logic signed [35:0] ox, oy, sx, sy;
    result_t            res;

    logic               out_valid_reg, out_valid_next;
    logic               skid_full_reg, skid_full_next;
    result_t            out_reg, out_next;
    result_t            skid_reg, skid_next;

    always_comb
    begin
        cap_x = (in_mx > OFFSET_CAP) ? OFFSET_CAP : in_mx;
        cap_y = (in_my > OFFSET_CAP) ? OFFSET_CAP : in_my;
        ox    = in_side.x_neg ? -36'(cap_x) : 36'(cap_x);
        oy    = in_side.y_neg ? -36'(cap_y) : 36'(cap_y);
        sx    = 36'(in_side.sum_x);
        sy    = 36'(in_side.sum_y);
        res.status = in_side.status;
        if (in_side.status == ST_OK)
        begin
            res.a_x = half_sat(sx + oy);
            res.a_y = half_sat(sy - ox);
            res.b_x = half_sat(sx - oy);
            res.b_y = half_sat(sy + ox);
        end
        else
        begin
            res.a_x = '0;
            res.a_y = '0;
            res.b_x = '0;
            res.b_y = '0;
        end
    end

    // The skid register catches one transaction while the output is stalled,
    // so the pipeline freezes only once both registers are full.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        out_next       = out_reg;
        skid_next      = skid_reg;
        if (skid_full_reg)
        begin
            if (m_tready)
            begin
                out_next       = skid_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (out_valid_reg && !m_tready)
        begin
            if (in_valid)
            begin
                skid_next      = res;
                skid_full_next = 1'b1;
            end
        end
        else
        begin
            out_valid_next = in_valid;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign en       = !skid_full_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.b_y, out_reg.b_x, out_reg.a_y, out_reg.a_x};
    assign m_tuser  = out_reg.status;

endmodule

// File: src/two_point_circle_centres_unit.sv
// Circle centres through two points at a configured radius.
//
// Input stream (s_*): one transaction carries a pair of points in Q16.16.
// Output stream (m_*): one transaction per input, carrying the two centres
// in tdata and the status code in tuser (0 valid, 1 coincident points,
// 2 points beyond the diameter; for either fault code all centres are zero).
// Configuration: radius_sq, the squared radius in unsigned Q32.16, is loaded
// whenever cfg_wr_en is high; change it only while no transaction is in flight.
//
// There are 41 register stages: six front stages for the differences, squares
// and 131-bit products, one stage per result bit of the 34-bit square root,
// and the output register. Throughput is one transaction per cycle while
// m_tready stays high. When the receiver stalls, a skid register holds one
// more result and the whole pipeline then freezes with s_tready low, losing
// nothing. Reset clears all valid flags and sets radius_sq to zero.
module two_point_circle_centres_unit import tpcc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [47:0]     cfg_wr_data,    // radius_sq
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [127:0]    s_tdata,        // first_x, first_y, second_x, second_y
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [127:0]    m_tdata,        // centre_a_x, centre_a_y, centre_b_x, centre_b_y
    output logic [1:0]      m_tuser         // status
);

`include "two_point_circle_centres_unit_defines.svh"

    localparam int QW = 50 + COORD_FRAC_BITS;
    localparam int NW = 65 + QW;

    logic [RADIUS_W-1:0]    radius_sq_reg;
    logic                   en;

    logic                   f_valid;
    side_t                  f_side;
    logic [D2_W-1:0]        f_d2;
    logic [NW-1:0]          f_nx, f_ny;

    logic                   r_valid;
    side_t                  r_side;
    logic [MAG_W-1:0]       r_mx, r_my;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            radius_sq_reg <= cfg_wr_data;
        end
    end

    assign s_tready = en;

    tpcc_front #(
        .FRAC_BITS  (COORD_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid && en),
        .first_x    (s_tdata[31:0]),
        .first_y    (s_tdata[63:32]),
        .second_x   (s_tdata[95:64]),
        .second_y   (s_tdata[127:96]),
        .radius_sq  (radius_sq_reg),
        .out_valid  (f_valid),
        .out_side   (f_side),
        .out_d2     (f_d2),
        .out_nx     (f_nx),
        .out_ny     (f_ny)
    );

    tpcc_root #(
        .NW         (NW)
    ) u_root (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (f_valid),
        .in_side    (f_side),
        .in_d2      (f_d2),
        .in_nx      (f_nx),
        .in_ny      (f_ny),
        .out_valid  (r_valid),
        .out_side   (r_side),
        .out_mx     (r_mx),
        .out_my     (r_my)
    );

    tpcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (r_valid),
        .in_side    (r_side),
        .in_mx      (r_mx),
        .in_my      (r_my),
        .en         (en),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    `TPCC_ASSERT_HOLDS(a_frozen_has_output, !s_tready, m_tvalid)
    `TPCC_ASSERT_NEXT(a_skid_drains, !s_tready && m_tready, s_tready)
    `TPCC_ASSERT_HOLDS(a_fault_zeroes, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
    `TPCC_ASSERT_HOLDS(a_status_known, m_tvalid,
        (m_tuser == ST_OK) || (m_tuser == ST_COINCIDENT) || (m_tuser == ST_FAR))

endmodule
